// File: hw/rtl/b64d_pkg.sv
// b64d_pkg: shared types, constants and the character lookup of the base64 decoder
// used by b64d_unit and base64_decoder; no dependencies
`timescale 1ns / 1ps

package b64d_pkg;

	localparam int unsigned SLOTS = 3;
	localparam logic [15:0] CAP_RESET = 16'hFFFF;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef struct packed {
		logic        ok;
		logic [5:0]  value;
	} sextet_t;

	typedef struct packed {
		logic [17:0] group;
		logic [1:0]  fill;
		logic [15:0] written;
		logic        stopped;
		logic        dropping;
	} dec_state_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        has;
		logic        done;
		logic        status;
		logic [15:0] count;
	} result_t;

	typedef struct packed {
		result_t [SLOTS-1:0] slot;
		logic [1:0]          n;
	} bundle_t;

	function automatic sextet_t sextet_of(input logic [7:0] ch);
		sextet_t s;
		s.ok    = 1'b1;
		s.value = 6'd0;
		if (ch inside {[8'h41:8'h5A]}) begin
			s.value = 6'(ch - 8'h41);
		end else if (ch inside {[8'h61:8'h7A]}) begin
			s.value = 6'(ch - 8'h61 + 8'd26);
		end else if (ch inside {[8'h30:8'h39]}) begin
			s.value = 6'(ch - 8'h30 + 8'd52);
		end else if (ch == CH_PLUS) begin
			s.value = 6'd62;
		end else if (ch == CH_SLASH) begin
			s.value = 6'd63;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

endpackage

// File: hw/rtl/b64d_unit.sv
// b64d_unit: per-character decode step, next message state and up to three result beats
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_unit (
	input  b64d_pkg::dec_state_t st,
	input  logic [7:0]           char_in,
	input  logic                 last_char,
	input  logic [15:0]          capacity,
	output b64d_pkg::dec_state_t nxt,
	output b64d_pkg::bundle_t    bnd
);

	b64d_pkg::sextet_t sx;
	logic [23:0] cat;
	logic [16:0] wc17;
	logic [16:0] cap17;
	logic        take;
	logic        ok0;
	logic        ok1;
	logic [7:0]  b0;
	logic [7:0]  b1;

	assign sx    = b64d_pkg::sextet_of(char_in);
	assign cat   = {st.group, sx.value};
	assign wc17  = {1'b0, st.written};
	assign cap17 = {1'b0, capacity};
	assign ok0   = (wc17 + 17'd1) <= cap17;
	assign ok1   = (wc17 + 17'd2) <= cap17;

	always_comb begin
		nxt  = st;
		bnd  = '0;
		take = 1'b0;
		b0   = 8'd0;
		b1   = 8'd0;
		if (st.dropping) begin
			if (last_char) begin
				nxt = '0;
			end
		end else begin
			take = !st.stopped && sx.ok;
			if (!st.stopped && !sx.ok) begin
				nxt.stopped = 1'b1;
			end
			if (take && st.fill == 2'd3) begin
				nxt.group = '0;
				nxt.fill  = 2'd0;
				if ((wc17 + 17'd3) > cap17) begin
					bnd.n       = 2'd1;
					bnd.slot[0] = '{data: 8'd0, has: 1'b0, done: 1'b1, status: 1'b1,
						count: st.written};
					nxt.dropping = 1'b1;
				end else begin
					bnd.n       = 2'd3;
					bnd.slot[0] = '{data: cat[23:16], has: 1'b1, done: 1'b0, status: 1'b0,
						count: st.written + 16'd1};
					bnd.slot[1] = '{data: cat[15:8], has: 1'b1, done: 1'b0, status: 1'b0,
						count: st.written + 16'd2};
					bnd.slot[2] = '{data: cat[7:0], has: 1'b1, done: last_char, status: 1'b0,
						count: st.written + 16'd3};
					nxt.written = st.written + 16'd3;
				end
				if (last_char) begin
					nxt = '0;
				end
			end else begin
				if (take) begin
					nxt.group = cat[17:0];
					nxt.fill  = st.fill + 2'd1;
				end
				if (last_char) begin
					// flush partial group
					b0 = (nxt.fill == 2'd2) ? nxt.group[11:4] : nxt.group[17:10];
					b1 = nxt.group[9:2];
					case (nxt.fill)
						2'd2: begin
							if (ok0) begin
								bnd.n       = 2'd1;
								bnd.slot[0] = '{data: b0, has: 1'b1, done: 1'b1, status: 1'b0,
									count: st.written + 16'd1};
							end else begin
								bnd.n       = 2'd1;
								bnd.slot[0] = '{data: 8'd0, has: 1'b0, done: 1'b1, status: 1'b1,
									count: st.written};
							end
						end
						2'd3: begin
							if (!ok0) begin
								bnd.n       = 2'd1;
								bnd.slot[0] = '{data: 8'd0, has: 1'b0, done: 1'b1, status: 1'b1,
									count: st.written};
							end else begin
								bnd.n       = 2'd2;
								bnd.slot[0] = '{data: b0, has: 1'b1, done: 1'b0, status: 1'b0,
									count: st.written + 16'd1};
								if (ok1) begin
									bnd.slot[1] = '{data: b1, has: 1'b1, done: 1'b1,
										status: 1'b0, count: st.written + 16'd2};
								end else begin
									bnd.slot[1] = '{data: 8'd0, has: 1'b0, done: 1'b1,
										status: 1'b1, count: st.written + 16'd1};
								end
							end
						end
						default: begin
							bnd.n       = 2'd1;
							bnd.slot[0] = '{data: 8'd0, has: 1'b0, done: 1'b1, status: 1'b0,
								count: st.written};
						end
					endcase
					nxt = '0;
				end
			end
		end
	end

endmodule

// File: hw/rtl/base64_decoder.sv
// base64_decoder: top level, input register, message state, result queue and config register
// depends on b64d_pkg and b64d_unit
//
//  channel | handshake            | beat
//  in      | in_valid / in_stall  | char_in, last_char
//  out     | out_valid / out_stall| data_byte, has_byte, message_done, status, byte_count
//  cfg     | cfg_valid / cfg_ready| buffer_capacity
//
// an accepted character is decoded in the following cycle from the input register and
// gives zero to three result beats, held in a three-entry result register.
// one character per cycle is taken while in_stall is low; a character that yields results
// waits in the input register while earlier results still drain, one beat per cycle while
// out_stall is low. a character reaches the output via the input and result registers.
// reset clears message state and sets the capacity to 65535; cfg_ready is always high.
`timescale 1ns / 1ps

module base64_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_byte,
	output logic        has_byte,
	output logic        message_done,
	output logic        status,
	output logic [15:0] byte_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] buffer_capacity
);

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 last_s1;
	logic [15:0]          capacity_q;
	b64d_pkg::dec_state_t state_q;
	b64d_pkg::dec_state_t state_nxt;
	b64d_pkg::bundle_t    bnd;
	b64d_pkg::result_t [b64d_pkg::SLOTS-1:0] res_q;
	logic [1:0]           cnt_q;
	logic                 beat_out;
	logic                 slot_free;
	logic                 adv;

	b64d_unit u_unit (
		.st       (state_q),
		.char_in  (char_s1),
		.last_char(last_s1),
		.capacity (capacity_q),
		.nxt      (state_nxt),
		.bnd      (bnd)
	);

	assign cfg_ready = 1'b1;
	assign out_valid = cnt_q != 2'd0;
	assign beat_out  = out_valid && !out_stall;
	assign slot_free = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall);
	assign adv       = valid_s1 && ((bnd.n == 2'd0) || slot_free);
	assign in_stall  = valid_s1 && !adv;

	assign data_byte    = res_q[0].data;
	assign has_byte     = res_q[0].has;
	assign message_done = res_q[0].done;
	assign status       = res_q[0].status;
	assign byte_count   = res_q[0].count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			capacity_q <= b64d_pkg::CAP_RESET;
			state_q    <= '0;
			cnt_q      <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= buffer_capacity;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				state_q <= state_nxt;
			end
			if (adv && bnd.n != 2'd0) begin
				cnt_q <= bnd.n;
			end else if (beat_out) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= char_in;
			last_s1 <= last_char;
		end
		if (adv && bnd.n != 2'd0) begin
			res_q <= bnd.slot;
		end else if (beat_out) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	// the end-of-message beat is always the final one queued
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_done |-> cnt_q == 2'd1)
		else $error("message end beat not last in result queue");

	// an overflow beat never carries a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> message_done && !has_byte)
		else $error("overflow beat malformed");

	// while dropping after overflow no group is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.dropping |-> state_q.fill == 2'd0)
		else $error("pending sextets while dropping");

	// the message state is clear after the last character of a message advances
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> state_q == '0)
		else $error("message state not cleared after last character");

endmodule
